FILE: design/tbf_pkg.sv
// ----------------------------------------------------------------------------
// tbf_pkg: shared types and constants of the torus broadcast forwarder
// Payload structs, geometry bundle, forward descriptors and code values.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int NODE_W    = 10;
  localparam int GRID_W    = 11;
  localparam int TREE_W    = 3;
  localparam int SIZE_W    = 16;
  localparam int REG_IDX_W = 2;
  localparam int MAX_NODES = 1024;

  // Register values after reset and the geometry that follows from them
  localparam int RST_ROWS    = 4;
  localparam int RST_COLS    = 4;
  localparam int RST_NODES   = 16;
  localparam int RST_MY_NODE = 0;
  localparam int RST_MR      = RST_MY_NODE / RST_COLS;
  localparam int RST_MC      = RST_MY_NODE % RST_COLS;
  localparam int RST_MR1     = (RST_MR + 1) % RST_ROWS;
  localparam int RST_DOWN    = (RST_MY_NODE + RST_COLS) % RST_NODES;
  localparam int RST_UP      = (RST_MY_NODE + RST_NODES - RST_COLS) % RST_NODES;

  localparam logic MODE_ARRIVE    = 1'b0;
  localparam logic MODE_ORIGINATE = 1'b1;

  localparam logic [TREE_W-1:0] TREE_ONE   = 3'd1;
  localparam logic [TREE_W-1:0] TREE_TWO   = 3'd2;
  localparam logic [TREE_W-1:0] TREE_THREE = 3'd3;
  localparam logic [TREE_W-1:0] TREE_FOUR  = 3'd4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_NODE_COUNT = 2'd2,
    REG_MY_NODE    = 2'd3
  } tbf_reg_t;

  typedef enum logic [1:0] {
    ACT_FORWARD = 2'd0,
    ACT_CONSUME = 2'd1,
    ACT_ERROR   = 2'd2
  } tbf_act_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } tbf_dir_t;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] src_node;
    logic [TREE_W-1:0] tree;
    logic [SIZE_W-1:0] size;
  } tbf_in_t;

  typedef struct packed {
    tbf_act_t          action;
    logic [NODE_W-1:0] dest_node;
    logic [TREE_W-1:0] out_tree;
    logic [NODE_W-1:0] out_src;
    logic [SIZE_W-1:0] out_size;
    logic              last;
  } tbf_out_t;

  // Geometry of this node, derived from the configuration registers
  typedef struct packed {
    logic [GRID_W-1:0] c_eff;
    logic [GRID_W-1:0] r_eff;
    logic [NODE_W-1:0] me;
    logic [NODE_W-1:0] mr;
    logic [NODE_W-1:0] mc;
    logic [NODE_W-1:0] mr1;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] down;
    logic [NODE_W-1:0] up;
  } tbf_geom_t;

  typedef struct packed {
    logic [1:0] nfwd;
    tbf_dir_t   dir0;
    tbf_dir_t   dir1;
  } tbf_fwd_t;

  // One classified item as it waits between front and back
  typedef struct packed {
    logic              orig;
    logic              err;
    logic [TREE_W-1:0] tree;
    logic [NODE_W-1:0] src;
    logic [SIZE_W-1:0] size;
    tbf_fwd_t          fwd;
  } tbf_desc_t;

  // Zero acts as one, large values saturate
  function automatic logic [GRID_W-1:0] grid_eff(logic [GRID_W-1:0] v);
    logic [GRID_W-1:0] r;
    if (v == '0) begin
      r = GRID_W'(1);
    end else if (v > GRID_W'(MAX_NODES)) begin
      r = GRID_W'(MAX_NODES);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/tbf_div_pipe.sv
// ----------------------------------------------------------------------------
// tbf_div_pipe: pipelined restoring divider
// Resolves up to BPS quotient bits per stage; a side payload rides alongside.
// ----------------------------------------------------------------------------
module tbf_div_pipe #(
  parameter int NW  = 10,
  parameter int DW  = 11,
  parameter int BPS = 4,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [PW-1:0] out_pay
);

  localparam int NSTG = (NW + BPS - 1) / BPS;

  logic [NSTG-1:0] v_r;
  logic [DW-1:0]   rem_r [NSTG];
  logic [NW-1:0]   num_r [NSTG];
  logic [NW-1:0]   quo_r [NSTG];
  logic [DW-1:0]   den_r [NSTG];
  logic [PW-1:0]   pay_r [NSTG];

  logic            v_in   [NSTG];
  logic [DW-1:0]   rem_in [NSTG];
  logic [NW-1:0]   num_in [NSTG];
  logic [NW-1:0]   quo_in [NSTG];
  logic [DW-1:0]   den_in [NSTG];
  logic [PW-1:0]   pay_in [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    localparam int NB = ((NW - s * BPS) < BPS) ? (NW - s * BPS) : BPS;

    logic [DW:0]   trial;
    logic [DW-1:0] rem_c;
    logic [NW-1:0] num_c;
    logic [NW-1:0] quo_c;

    if (s == 0) begin : g_head
      assign v_in[s]   = in_valid;
      assign rem_in[s] = '0;
      assign num_in[s] = in_num;
      assign quo_in[s] = '0;
      assign den_in[s] = in_den;
      assign pay_in[s] = in_pay;
    end else begin : g_body
      assign v_in[s]   = v_r[s-1];
      assign rem_in[s] = rem_r[s-1];
      assign num_in[s] = num_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign pay_in[s] = pay_r[s-1];
    end

    always_comb begin
      rem_c = rem_in[s];
      num_c = num_in[s];
      quo_c = quo_in[s];
      trial = '0;
      for (int b = 0; b < NB; b++) begin
        trial = {rem_c, num_c[NW-1]};
        num_c = num_c << 1;
        if (trial >= {1'b0, den_in[s]}) begin
          rem_c = DW'(trial - {1'b0, den_in[s]});
          quo_c = NW'({quo_c, 1'b1});
        end else begin
          rem_c = trial[DW-1:0];
          quo_c = NW'({quo_c, 1'b0});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        num_r[s] <= num_c;
        quo_r[s] <= quo_c;
        den_r[s] <= den_in[s];
        pay_r[s] <= pay_in[s];
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_quo   = quo_r[NSTG-1];
  assign out_rem   = rem_r[NSTG-1];
  assign out_pay   = pay_r[NSTG-1];

endmodule

FILE: design/tbf_geom.sv
// ----------------------------------------------------------------------------
// tbf_geom: configuration registers and node geometry
// A serial divider recomputes row, column and wrapped neighbors after a write.
// ----------------------------------------------------------------------------
module tbf_geom (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tbf_pkg::REG_IDX_W-1:0]    cfg_idx,
  input  logic [tbf_pkg::GRID_W-1:0]       cfg_data,
  output tbf_pkg::tbf_geom_t               geom,
  output logic                             busy
);
  import tbf_pkg::*;

  localparam int DIV_STEPS = GRID_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {G_IDLE, G_LOAD, G_DIV} gstate_t;
  typedef enum logic [1:0] {JOB_ME_DIV, JOB_ROW_WRAP, JOB_DOWN, JOB_UP} job_t;

  gstate_t           state_r;
  job_t              job_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GRID_W-1:0] rows_r;
  logic [GRID_W-1:0] cols_r;
  logic [GRID_W-1:0] nodes_r;
  logic [NODE_W-1:0] me_r;
  logic [GRID_W-1:0] num_r;
  logic [GRID_W-1:0] rem_r;
  logic [GRID_W-1:0] quo_r;
  logic [NODE_W-1:0] mr_r;
  logic [NODE_W-1:0] mc_r;
  logic [NODE_W-1:0] mr1_r;
  logic [NODE_W-1:0] down_r;
  logic [NODE_W-1:0] up_r;

  logic [GRID_W-1:0] c_eff;
  logic [GRID_W-1:0] r_eff;
  logic [GRID_W-1:0] n_eff;
  logic [GRID_W:0]   up_x;
  logic              up_neg;
  logic [GRID_W-1:0] up_mag;
  logic [GRID_W-1:0] div_num;
  logic [GRID_W-1:0] div_den;
  logic [GRID_W:0]   trial;
  logic              ge;
  logic [GRID_W-1:0] rem_step;
  logic [GRID_W-1:0] quo_step;
  logic              done;
  logic [GRID_W:0]   right_x;
  logic [GRID_W:0]   left_x;

  assign c_eff = grid_eff(cols_r);
  assign r_eff = grid_eff(rows_r);
  assign n_eff = grid_eff(nodes_r);

  // me + n - c may go negative; the remainder then takes the dividend's sign
  assign up_x   = {2'b00, me_r} + {1'b0, n_eff} - {1'b0, c_eff};
  assign up_neg = up_x[GRID_W];
  assign up_mag = up_neg ? GRID_W'(-up_x) : up_x[GRID_W-1:0];

  always_comb begin
    unique case (job_r)
      JOB_ME_DIV: begin
        div_num = {1'b0, me_r};
        div_den = c_eff;
      end
      JOB_ROW_WRAP: begin
        div_num = {1'b0, mr_r} + GRID_W'(1);
        div_den = r_eff;
      end
      JOB_DOWN: begin
        div_num = {1'b0, me_r} + c_eff;
        div_den = n_eff;
      end
      JOB_UP: begin
        div_num = up_mag;
        div_den = n_eff;
      end
      default: begin
        div_num = '0;
        div_den = GRID_W'(1);
      end
    endcase
  end

  assign trial    = {rem_r, num_r[GRID_W-1]};
  assign ge       = trial >= {1'b0, div_den};
  assign rem_step = ge ? GRID_W'(trial - {1'b0, div_den}) : trial[GRID_W-1:0];
  assign quo_step = {quo_r[GRID_W-2:0], ge};
  assign done     = (state_r == G_DIV) && (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      job_r   <= JOB_ME_DIV;
      cnt_r   <= '0;
      rows_r  <= GRID_W'(RST_ROWS);
      cols_r  <= GRID_W'(RST_COLS);
      nodes_r <= GRID_W'(RST_NODES);
      me_r    <= NODE_W'(RST_MY_NODE);
      num_r   <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
      mr_r    <= NODE_W'(RST_MR);
      mc_r    <= NODE_W'(RST_MC);
      mr1_r   <= NODE_W'(RST_MR1);
      down_r  <= NODE_W'(RST_DOWN);
      up_r    <= NODE_W'(RST_UP);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_ROWS:  rows_r  <= cfg_data;
        REG_GRID_COLS:  cols_r  <= cfg_data;
        REG_NODE_COUNT: nodes_r <= cfg_data;
        REG_MY_NODE:    me_r    <= cfg_data[NODE_W-1:0];
      endcase
      state_r <= G_LOAD;
      job_r   <= JOB_ME_DIV;
    end else begin
      unique case (state_r)
        G_IDLE: state_r <= G_IDLE;
        G_LOAD: begin
          num_r   <= div_num;
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= G_DIV;
        end
        G_DIV: begin
          num_r <= num_r << 1;
          rem_r <= rem_step;
          quo_r <= quo_step;
          cnt_r <= cnt_r + CNT_W'(1);
          if (done) begin
            unique case (job_r)
              JOB_ME_DIV: begin
                mr_r    <= quo_step[NODE_W-1:0];
                mc_r    <= rem_step[NODE_W-1:0];
                job_r   <= JOB_ROW_WRAP;
                state_r <= G_LOAD;
              end
              JOB_ROW_WRAP: begin
                mr1_r   <= rem_step[NODE_W-1:0];
                job_r   <= JOB_DOWN;
                state_r <= G_LOAD;
              end
              JOB_DOWN: begin
                down_r  <= rem_step[NODE_W-1:0];
                job_r   <= JOB_UP;
                state_r <= G_LOAD;
              end
              JOB_UP: begin
                up_r    <= up_neg ? NODE_W'(-rem_step) : rem_step[NODE_W-1:0];
                job_r   <= JOB_ME_DIV;
                state_r <= G_IDLE;
              end
            endcase
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  // Row-local wrap for left and right
  assign right_x = ({1'b0, mc_r} == c_eff - GRID_W'(1)) ?
                   {2'b00, me_r} + (GRID_W + 1)'(1) - {1'b0, c_eff} :
                   {2'b00, me_r} + (GRID_W + 1)'(1);
  assign left_x  = (mc_r == '0) ?
                   {2'b00, me_r} + {1'b0, c_eff} - (GRID_W + 1)'(1) :
                   {2'b00, me_r} - (GRID_W + 1)'(1);

  assign geom.c_eff = c_eff;
  assign geom.r_eff = r_eff;
  assign geom.me    = me_r;
  assign geom.mr    = mr_r;
  assign geom.mc    = mc_r;
  assign geom.mr1   = mr1_r;
  assign geom.right = right_x[NODE_W-1:0];
  assign geom.left  = left_x[NODE_W-1:0];
  assign geom.down  = down_r;
  assign geom.up    = up_r;

  assign busy = (state_r != G_IDLE);

endmodule

FILE: design/tbf_front.sv
// ----------------------------------------------------------------------------
// tbf_front: item intake and classification
// Splits the source into row and column, then picks the forward directions.
// ----------------------------------------------------------------------------
module tbf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tbf_pkg::tbf_in_t    in_item,
  input  tbf_pkg::tbf_geom_t  geom,
  input  logic                q_full,
  output logic                ready,
  output logic                q_push,
  output tbf_pkg::tbf_desc_t  q_wdata
);
  import tbf_pkg::*;

  typedef struct packed {
    tbf_in_t           item;
    logic [NODE_W-1:0] sr;
    logic [NODE_W-1:0] sc;
  } mid_t;

  localparam int IN_W  = $bits(tbf_in_t);
  localparam int MID_W = $bits(mid_t);

  logic              v1;
  logic [NODE_W-1:0] quo1;
  logic [GRID_W-1:0] rem1;
  logic [IN_W-1:0]   pay1;
  mid_t              mid_in;
  logic              v2;
  logic [GRID_W-1:0] rem2;
  logic [MID_W-1:0]  pay2;
  mid_t              mid_out;

  logic [NODE_W-1:0] sr1;
  logic              srow;
  logic              scol;
  logic [GRID_W-1:0] sc_nx;
  logic [GRID_W-1:0] mc_nx;
  logic              sc1_eq_mc;
  logic              mc1_eq_sc;
  logic              mr1_eq_sr;
  logic              sr1_eq_mr;
  logic [GRID_W:0]   lsrc;
  logic              lsrc_is_me;
  tbf_fwd_t          fw;
  logic              bad_tree;

  function automatic tbf_fwd_t pick(logic ca, tbf_dir_t da, logic cb, tbf_dir_t db);
    tbf_fwd_t f;
    f.nfwd = {1'b0, ca} + {1'b0, cb};
    f.dir0 = ca ? da : db;
    f.dir1 = db;
    return f;
  endfunction

  // Hold every stage while a finished item cannot enter the queue
  assign ready  = !(v2 && q_full);
  assign q_push = v2 && !q_full;

  tbf_div_pipe #(
    .NW (NODE_W),
    .DW (GRID_W),
    .BPS(4),
    .PW (IN_W)
  ) u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (ready),
    .in_valid (in_valid),
    .in_num   (in_item.src_node),
    .in_den   (geom.c_eff),
    .in_pay   (in_item),
    .out_valid(v1),
    .out_quo  (quo1),
    .out_rem  (rem1),
    .out_pay  (pay1)
  );

  assign mid_in.item = tbf_in_t'(pay1);
  assign mid_in.sr   = quo1;
  assign mid_in.sc   = rem1[NODE_W-1:0];

  tbf_div_pipe #(
    .NW (GRID_W),
    .DW (GRID_W),
    .BPS(4),
    .PW (MID_W)
  ) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (ready),
    .in_valid (v1),
    .in_num   ({1'b0, quo1} + GRID_W'(1)),
    .in_den   (geom.r_eff),
    .in_pay   (mid_in),
    .out_valid(v2),
    .out_quo  (),
    .out_rem  (rem2),
    .out_pay  (pay2)
  );

  assign mid_out = mid_t'(pay2);
  assign sr1     = rem2[NODE_W-1:0];

  assign srow      = (mid_out.sr == geom.mr);
  assign scol      = (mid_out.sc == geom.mc);
  assign sc_nx     = ({1'b0, mid_out.sc} + GRID_W'(1) == geom.c_eff) ?
                     '0 : {1'b0, mid_out.sc} + GRID_W'(1);
  assign mc_nx     = ({1'b0, geom.mc} + GRID_W'(1) == geom.c_eff) ?
                     '0 : {1'b0, geom.mc} + GRID_W'(1);
  assign sc1_eq_mc = (sc_nx == {1'b0, geom.mc});
  assign mc1_eq_sc = (mc_nx == {1'b0, mid_out.sc});
  assign mr1_eq_sr = (geom.mr1 == mid_out.sr);
  assign sr1_eq_mr = (sr1 == geom.mr);

  // Left neighbor of the source, unmasked
  assign lsrc = (mid_out.sc == '0) ?
                {2'b00, mid_out.item.src_node} + {1'b0, geom.c_eff} - (GRID_W + 1)'(1) :
                {2'b00, mid_out.item.src_node} - (GRID_W + 1)'(1);
  assign lsrc_is_me = (lsrc == {2'b00, geom.me});

  always_comb begin
    fw       = pick(1'b0, DIR_RIGHT, 1'b0, DIR_RIGHT);
    bad_tree = 1'b0;
    unique case (mid_out.item.tree)
      TREE_ONE: begin
        if (srow && scol) fw = pick(1'b1, DIR_RIGHT, 1'b0, DIR_RIGHT);
        else if (srow)    fw = pick(!lsrc_is_me, DIR_RIGHT, 1'b1, DIR_DOWN);
        else if (!scol)   fw = pick(sc1_eq_mc, DIR_LEFT, !mr1_eq_sr, DIR_DOWN);
      end
      TREE_TWO: begin
        if (srow && scol) fw = pick(1'b1, DIR_DOWN, 1'b0, DIR_DOWN);
        else if (scol)    fw = pick(!mr1_eq_sr, DIR_DOWN, 1'b1, DIR_RIGHT);
        else if (!srow)   fw = pick(sr1_eq_mr, DIR_UP, !mc1_eq_sc, DIR_RIGHT);
      end
      TREE_THREE: begin
        if (srow && scol) fw = pick(1'b1, DIR_LEFT, 1'b0, DIR_LEFT);
        else if (srow)    fw = pick(!sc1_eq_mc, DIR_LEFT, 1'b1, DIR_UP);
        else if (!scol)   fw = pick(mc1_eq_sc, DIR_RIGHT, !sr1_eq_mr, DIR_UP);
      end
      TREE_FOUR: begin
        if (srow && scol) fw = pick(1'b1, DIR_UP, 1'b0, DIR_UP);
        else if (scol)    fw = pick(1'b1, DIR_LEFT, !sr1_eq_mr, DIR_UP);
        else if (!srow)   fw = pick(!sc1_eq_mc, DIR_LEFT, mr1_eq_sr, DIR_DOWN);
      end
      default: bad_tree = 1'b1;
    endcase
  end

  assign q_wdata.orig = (mid_out.item.mode == MODE_ORIGINATE);
  assign q_wdata.err  = (mid_out.item.mode == MODE_ARRIVE) && bad_tree;
  assign q_wdata.tree = mid_out.item.tree;
  assign q_wdata.src  = mid_out.item.src_node;
  assign q_wdata.size = mid_out.item.size;
  assign q_wdata.fwd  = fw;

endmodule

FILE: design/tbf_fifo.sv
// ----------------------------------------------------------------------------
// tbf_fifo: small descriptor queue
// Decouples classification from result generation.
// ----------------------------------------------------------------------------
module tbf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: design/tbf_back.sv
// ----------------------------------------------------------------------------
// tbf_back: result generation
// Expands a descriptor into forward/consume/error results, one a cycle on pop.
// ----------------------------------------------------------------------------
module tbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tbf_pkg::tbf_desc_t  q_data,
  output logic                q_pop,
  input  tbf_pkg::tbf_geom_t  geom,
  input  logic                pop,
  output logic                empty,
  output tbf_pkg::tbf_out_t   out_data
);
  import tbf_pkg::*;

  logic [2:0] step_r;
  logic       out_v_r;
  tbf_out_t   out_r;

  tbf_out_t   res;
  logic       done;
  logic [1:0] t;
  logic       take;

  function automatic logic [NODE_W-1:0] node_of(tbf_dir_t d, tbf_geom_t g);
    logic [NODE_W-1:0] n;
    unique case (d)
      DIR_RIGHT: n = g.right;
      DIR_DOWN:  n = g.down;
      DIR_LEFT:  n = g.left;
      DIR_UP:    n = g.up;
    endcase
    return n;
  endfunction

  function automatic tbf_dir_t orig_dir(logic [1:0] ti);
    tbf_dir_t d;
    unique case (ti)
      2'd0: d = DIR_RIGHT;
      2'd1: d = DIR_DOWN;
      2'd2: d = DIR_LEFT;
      2'd3: d = DIR_UP;
    endcase
    return d;
  endfunction

  assign t = step_r[2:1];

  always_comb begin
    res.action    = ACT_CONSUME;
    res.dest_node = '0;
    res.out_tree  = q_data.tree;
    res.out_src   = q_data.src;
    res.out_size  = q_data.size;
    res.last      = 1'b0;
    done          = 1'b0;
    if (q_data.orig) begin
      // Two results per tree: forward, then consume with that tree's share
      res.out_tree = {1'b0, t} + TREE_W'(1);
      res.out_src  = geom.me;
      res.out_size = {2'b00, q_data.size[SIZE_W-1:2]} +
                     {{(SIZE_W - 1){1'b0}}, (q_data.size[1:0] > t)};
      if (!step_r[0]) begin
        res.action    = ACT_FORWARD;
        res.dest_node = node_of(orig_dir(t), geom);
      end else begin
        res.last = (t == 2'd3);
        done     = (t == 2'd3);
      end
    end else if (q_data.err) begin
      res.action = ACT_ERROR;
      res.last   = 1'b1;
      done       = 1'b1;
    end else if (step_r < {1'b0, q_data.fwd.nfwd}) begin
      res.action    = ACT_FORWARD;
      res.dest_node = node_of(step_r[0] ? q_data.fwd.dir1 : q_data.fwd.dir0, geom);
    end else begin
      res.last = 1'b1;
      done     = 1'b1;
    end
  end

  // Load a result if a descriptor waits and the output is free or being taken
  assign take  = q_valid && (!out_v_r || pop);
  assign q_pop = take && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        out_v_r <= 1'b1;
        step_r  <= done ? '0 : step_r + 3'd1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign empty    = !out_v_r;
  assign out_data = out_r;

endmodule

FILE: design/torus_broadcast_forwarder.sv
// ----------------------------------------------------------------------------
// torus_broadcast_forwarder: broadcast forwarding for one node of a 2D torus
// Items pass column and row dividers, queue and output register; results leave
// one per cycle while pop is held. Arriving packet: 1 to 3 results, originate: 8,
// set by back end. Reset: queue empty, grid 4x4, node 0; after a config write
// full stays high while the serial divider recomputes the node geometry.
// ----------------------------------------------------------------------------
module torus_broadcast_forwarder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  tbf_pkg::tbf_in_t                 in_data,
  output logic                             empty,
  input  logic                             pop,
  output tbf_pkg::tbf_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [tbf_pkg::REG_IDX_W-1:0]    cfg_idx,
  input  logic [tbf_pkg::GRID_W-1:0]       cfg_data
);
  import tbf_pkg::*;

  localparam int DESC_W = $bits(tbf_desc_t);

  tbf_geom_t        geom;
  logic             geom_busy;
  logic             front_ready;
  logic             accept;
  logic             q_push;
  tbf_desc_t        q_wdata;
  logic             q_full;
  logic             q_pop;
  logic [DESC_W-1:0] q_rdata;
  logic             q_empty;

  assign full   = cfg_we || geom_busy || !front_ready;
  assign accept = push && !full;

  tbf_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .geom    (geom),
    .busy    (geom_busy)
  );

  tbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(accept),
    .in_item (in_data),
    .geom    (geom),
    .q_full  (q_full),
    .ready   (front_ready),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  tbf_fifo #(
    .WIDTH(DESC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  tbf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_data  (tbf_desc_t'(q_rdata)),
    .q_pop   (q_pop),
    .geom    (geom),
    .pop     (pop),
    .empty   (empty),
    .out_data(out_data)
  );

endmodule
